// ----- sv/cbor_encoded_size_accumulator_macros.svh -----
// assertion macros for the cbor encoded size accumulator
// expects clk and rst (synchronous, active high) in the module that uses them
`ifndef CBOR_ENCODED_SIZE_ACCUMULATOR_MACROS_SVH
`define CBOR_ENCODED_SIZE_ACCUMULATOR_MACROS_SVH

// condition holds in the same cycle
`define CESA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define CESA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cesa_pkg.sv -----
// shared types and codes for the cbor encoded size accumulator
// no dependencies
`timescale 1ns / 1ps

package cesa_pkg;

  localparam logic CMD_BREAK = 1'b1;

  typedef enum logic [3:0] {
    NT_FALSE        = 4'd0,
    NT_TRUE         = 4'd1,
    NT_NULL         = 4'd2,
    NT_UNDEF        = 4'd3,
    NT_UINT         = 4'd4,
    NT_INT          = 4'd5,
    NT_BYTES        = 4'd6,
    NT_TEXT         = 4'd7,
    NT_BYTES_CHUNKS = 4'd8,
    NT_TEXT_CHUNKS  = 4'd9,
    NT_ARRAY        = 4'd10,
    NT_MAP          = 4'd11,
    NT_TAG          = 4'd12,
    NT_SIMPLE       = 4'd13,
    NT_DOUBLE       = 4'd14,
    NT_INVALID      = 4'd15
  } node_type_t;

  typedef struct packed {
    logic        command;
    node_type_t  node_type;
    logic        indefinite;
    logic [63:0] item_value;
    logic        last_item;
  } item_t;

  // sized item handed to the accumulator
  typedef struct packed {
    logic [64:0] inc;
    logic        bad;
    logic        last;
  } sized_t;

endpackage

// ----- sv/cesa_size_stage.sv -----
// input register, per-item byte count logic and sized-item register
// depends on cesa_pkg
`timescale 1ns / 1ps

module cesa_size_stage
  import cesa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  item_t  item,
  input  logic   float_enable,
  output logic   sz_valid,
  output sized_t sz,
  input  logic   sz_ready
);

  localparam logic [10:0] EXP_BIAS_F32 = 11'd896;
  localparam logic [10:0] SUB_SHIFT    = 11'd926;
  localparam logic [10:0] HALF_SHIFT   = 11'd126;

  logic   s1_valid;
  item_t  s1_item;
  logic   s1_ready;
  logic   s2_ready;
  sized_t sized_next;

  function automatic logic [3:0] header_bytes(input logic [63:0] v);
    logic [3:0] res;
    if (v < 64'd24) res = 4'd1;
    else if (v < 64'd256) res = 4'd2;
    else if (v < 64'd65536) res = 4'd3;
    else if (v < 64'h1_0000_0000) res = 4'd5;
    else res = 4'd9;
    return res;
  endfunction

  // header byte plus the payload of the shortest exact float form
  function automatic logic [3:0] double_bytes(input logic [63:0] bits);
    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] full;
    logic [22:0] fman;
    logic [10:0] fexp;
    logic [10:0] r;
    logic [52:0] rmask;
    logic [10:0] sh_w;
    logic [4:0]  sh;
    logic [22:0] shmask;
    logic [3:0]  res;
    e      = bits[62:52];
    m      = bits[51:0];
    full   = {1'b1, m};
    fman   = m[51:29];
    fexp   = e - EXP_BIAS_F32;
    r      = SUB_SHIFT - e;
    rmask  = (53'd1 << r[5:0]) - 53'd1;
    sh_w   = HALF_SHIFT - fexp;
    sh     = sh_w[4:0];
    shmask = (23'd1 << sh) - 23'd1;
    if (e == 11'h7FF) begin
      res = 4'd3;
    end else if (e == 11'd0) begin
      res = (m == 52'd0) ? 4'd3 : 4'd9;
    end else if (e >= 11'd897 && e <= 11'd1150) begin
      if (m[28:0] != 29'd0) res = 4'd9;
      else if (m[41:29] != 13'd0) res = 4'd5;
      else if (fexp >= 11'd113 && fexp <= 11'd142) res = 4'd3;
      else if (fexp >= 11'd103 && fexp <= 11'd112) res = ((fman & shmask) != 23'd0) ? 4'd5 : 4'd3;
      else res = 4'd5;
    end else if (e >= 11'd874 && e <= 11'd896) begin
      // binary32 subnormal, never fits binary16
      res = ((full & rmask) != 53'd0) ? 4'd9 : 4'd5;
    end else begin
      res = 4'd9;
    end
    return res;
  endfunction

  always_comb begin
    logic [63:0] arg;
    logic [3:0]  hdr;
    arg = s1_item.item_value;
    if (s1_item.node_type == NT_INT) arg = ~s1_item.item_value;
    else if (s1_item.node_type == NT_MAP) arg = {1'b0, s1_item.item_value[63:1]};
    hdr = header_bytes(arg);
    sized_next.inc  = 65'd0;
    sized_next.bad  = 1'b0;
    sized_next.last = s1_item.last_item;
    if (s1_item.command == CMD_BREAK) begin
      sized_next.inc = 65'd1;
    end else begin
      unique case (s1_item.node_type)
        NT_FALSE, NT_TRUE, NT_NULL, NT_UNDEF, NT_BYTES_CHUNKS, NT_TEXT_CHUNKS: begin
          sized_next.inc = 65'd1;
        end
        NT_UINT, NT_INT, NT_TAG, NT_SIMPLE: begin
          sized_next.inc = 65'(hdr);
        end
        NT_BYTES, NT_TEXT: begin
          sized_next.inc = {1'b0, s1_item.item_value} + 65'(hdr);
        end
        NT_ARRAY, NT_MAP: begin
          sized_next.inc = s1_item.indefinite ? 65'd1 : 65'(hdr);
        end
        NT_DOUBLE: begin
          sized_next.inc = float_enable ? 65'(double_bytes(s1_item.item_value)) : 65'd0;
        end
        NT_INVALID: begin
          sized_next.bad = 1'b1;
        end
        default: begin
          sized_next.bad = 1'b1;
        end
      endcase
    end
  end

  assign s2_ready = !sz_valid || sz_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      sz_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) sz_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) s1_item <= item;
    if (s2_ready && s1_valid) sz <= sized_next;
  end

endmodule

// ----- sv/cesa_accum.sv -----
// running byte total, sticky error and result register
// depends on cesa_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "cbor_encoded_size_accumulator_macros.svh"

module cesa_accum
  import cesa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sz_valid,
  input  sized_t      sz,
  output logic        sz_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] encoded_size,
  output logic        size_error
);

  logic [63:0] total;
  logic        err_seen;
  logic        take;
  logic        out_free;
  logic [65:0] sum;
  logic [65:0] sum_p1;
  logic        err_add;
  logic        err_final;
  logic [63:0] total_next;

  assign out_free = !out_valid || !out_stall;
  // only a last item needs room in the result register
  assign sz_ready = !sz.last || out_free;
  assign take     = sz_valid && sz_ready;

  // total + inc and total + inc + 1 side by side
  assign sum    = {2'b00, total} + {1'b0, sz.inc};
  assign sum_p1 = {2'b00, total} + {1'b0, sz.inc} + 66'd1;

  assign err_add    = err_seen || sz.bad || (sum[65:64] != 2'b00);
  assign err_final  = err_add || (sum_p1[65:64] != 2'b00);
  assign total_next = err_add ? total : sum[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      err_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        if (sz.last) begin
          total    <= '0;
          err_seen <= 1'b0;
        end else begin
          total    <= total_next;
          err_seen <= err_add;
        end
      end
      if (take && sz.last) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && sz.last) begin
      encoded_size <= err_final ? 64'd0 : sum_p1[63:0];
      size_error   <= err_final;
    end
  end

  `CESA_ASSERT_NOW(a_err_zero_size, out_valid && size_error, encoded_size == 64'd0,
                   "error result carries a nonzero size")
  `CESA_ASSERT_NEXT(a_clear_after_emit, take && sz.last, total == 64'd0 && !err_seen,
                    "running state not cleared after result")
  `CESA_ASSERT_NOW(a_no_overwrite, take && sz.last, !(out_valid && out_stall),
                   "result register overwritten while held")
  `CESA_ASSERT_NEXT(a_total_frozen, take && !sz.last && err_seen, total == $past(total),
                    "total moved while error is set")

endmodule

// ----- sv/cbor_encoded_size_accumulator.sv -----
// top level of the cbor encoded size accumulator: config register and the two stages
// depends on cesa_pkg, cesa_size_stage and cesa_accum
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------------
//  input   | in_valid / in_stall   | command, node_type, indefinite, item_value, last_item
//  output  | out_valid / out_stall | encoded_size, size_error
//  config  | cfg_write             | cfg_data (float_enable)
//
// one item per cycle while in_stall is low; the 66-bit accumulator add is the loop that sets the rate
// a result passes through the input register, the sized-item register and the result register after its last item
// reset clears the running total and error and sets float_enable to 1
// out_stall holds back only items marked last; other items keep draining behind a waiting result
`timescale 1ns / 1ps

module cbor_encoded_size_accumulator
  import cesa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [3:0]  node_type,
  input  logic        indefinite,
  input  logic [63:0] item_value,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] encoded_size,
  output logic        size_error
);

  logic   float_enable;
  item_t  item;
  logic   in_ready;
  logic   sz_valid;
  logic   sz_ready;
  sized_t sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      float_enable <= 1'b1;
    end else if (cfg_write) begin
      float_enable <= cfg_data;
    end
  end

  assign item.command    = command;
  assign item.node_type  = node_type_t'(node_type);
  assign item.indefinite = indefinite;
  assign item.item_value = item_value;
  assign item.last_item  = last_item;

  assign in_stall = !in_ready;

  cesa_size_stage u_size (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .item         (item),
    .float_enable (float_enable),
    .sz_valid     (sz_valid),
    .sz           (sz),
    .sz_ready     (sz_ready)
  );

  cesa_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .sz_valid     (sz_valid),
    .sz           (sz),
    .sz_ready     (sz_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .encoded_size (encoded_size),
    .size_error   (size_error)
  );

endmodule

// ----- test/tb_cbor_encoded_size_accumulator.sv -----
// testbench for cbor_encoded_size_accumulator: a directed table, then random item streams
// every emitted size is checked against the table value or a size predictor kept in the bench; needs cesa_pkg
`timescale 1ns / 1ps

module tb_cbor_encoded_size_accumulator;
  import cesa_pkg::*;

  typedef struct {
    logic [63:0] size;
    logic        err;
  } total_t;

  typedef struct {
    item_t       it;
    bit          known;
    logic [63:0] size;
    logic        err;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        command = 1'b0;
  logic [3:0]  node_type = 4'd0;
  logic        indefinite = 1'b0;
  logic [63:0] item_value = 64'd0;
  logic        last_item = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [63:0] encoded_size;
  logic        size_error;

  // predictor state
  logic [63:0] run_total = 64'd0;
  logic        run_err = 1'b0;
  logic        float_en = 1'b1;

  total_t   sizes_due[$];
  total_t   want_total;
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  bit       idle_on = 1'b1;
  int       stall_left = 0;
  int       cyc = 0;

  cbor_encoded_size_accumulator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .node_type    (node_type),
    .indefinite   (indefinite),
    .item_value   (item_value),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .encoded_size (encoded_size),
    .size_error   (size_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] head_len(logic [63:0] v);
    if (v < 64'd24) return 64'd1;
    if (v < 64'd256) return 64'd2;
    if (v < 64'd65536) return 64'd3;
    if (v < 64'h1_0000_0000) return 64'd5;
    return 64'd9;
  endfunction

  // payload bytes of the shortest exact float form: 2 half, 4 single, 8 double
  function automatic logic [63:0] float_payload(logic [63:0] bits);
    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] full;
    logic [31:0] fman;
    int          ue;
    int          r;
    int          fexp;
    int          sh;
    e = bits[62:52];
    m = bits[51:0];
    if (e == 11'h7FF) return 64'd2;
    if (e == 11'h000) return (m == 52'd0) ? 64'd2 : 64'd8;
    ue = int'(e) - 1023;
    if (ue >= -126 && ue <= 127) begin
      if (m[28:0] != 29'd0) return 64'd8;
      fexp = ue + 127;
      fman = {9'd0, m[51:29]};
    end else if (ue >= -149 && ue < -126) begin
      // single subnormal: the hidden bit moves into the fraction
      r = -97 - ue;
      full = {1'b1, m};
      if ((full & ((53'd1 << r) - 53'd1)) != 53'd0) return 64'd8;
      fexp = 0;
      fman = 32'(full >> r);
    end else begin
      return 64'd8;
    end
    if (fman[12:0] != 13'd0) return 64'd4;
    if (fexp >= 113 && fexp <= 142) return 64'd2;
    if (fexp >= 103 && fexp < 113) begin
      sh = 126 - fexp;
      if ((fman & ((32'd1 << sh) - 32'd1)) != 32'd0) return 64'd4;
      return 64'd2;
    end
    return 64'd4;
  endfunction

  function automatic void add_to_total(logic [63:0] n);
    if (run_err) return;
    if ({1'b0, run_total} + {1'b0, n} > 65'h0_FFFF_FFFF_FFFF_FFFF) run_err = 1'b1;
    else run_total = run_total + n;
  endfunction

  // advances the predicted total by one item; returns 1 when the item closes a tree
  function automatic bit tally_item(input item_t it, output total_t res);
    logic [63:0] v;
    v = it.item_value;
    if (it.command == CMD_BREAK) begin
      add_to_total(64'd1);
    end else begin
      case (it.node_type)
        NT_FALSE, NT_TRUE, NT_NULL, NT_UNDEF, NT_BYTES_CHUNKS, NT_TEXT_CHUNKS:
          add_to_total(64'd1);
        NT_UINT, NT_TAG, NT_SIMPLE: add_to_total(head_len(v));
        NT_INT: add_to_total(head_len(~v));
        NT_BYTES, NT_TEXT: begin
          add_to_total(head_len(v));
          add_to_total(v);
        end
        NT_ARRAY: add_to_total(it.indefinite ? 64'd1 : head_len(v));
        NT_MAP: add_to_total(it.indefinite ? 64'd1 : head_len(v >> 1));
        NT_DOUBLE: if (float_en) add_to_total(64'd1 + float_payload(v));
        default: run_err = 1'b1;
      endcase
    end
    if (!it.last_item) return 1'b0;
    if (!run_err && run_total == '1) run_err = 1'b1;
    res.size = run_err ? 64'd0 : run_total + 64'd1;
    res.err = run_err;
    run_total = 64'd0;
    run_err = 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_row(logic cmd, node_type_t nt, logic indef, logic [63:0] val,
                                  logic last, bit known = 1'b0, logic [63:0] ksize = 64'd0,
                                  logic kerr = 1'b0);
    dir_row_t r;
    r.it.command = cmd;
    r.it.node_type = nt;
    r.it.indefinite = indef;
    r.it.item_value = val;
    r.it.last_item = last;
    r.known = known;
    r.size = ksize;
    r.err = kerr;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [63:0] rand_boundary();
    case ($urandom_range(0, 8))
      0: return 64'd23;
      1: return 64'd24;
      2: return 64'd255;
      3: return 64'd256;
      4: return 64'd65535;
      5: return 64'd65536;
      6: return 64'hFFFF_FFFF;
      7: return 64'h1_0000_0000;
      default: return '1;
    endcase
  endfunction

  function automatic logic [63:0] rand_arg();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 23));
      1: return rand_boundary();
      2: return 64'($urandom_range(0, 65535));
      3: return 64'($urandom);
      4: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // doubles aimed at each precision band, the subnormal ranges and the specials
  function automatic logic [63:0] rand_double();
    logic        sgn;
    logic [10:0] e;
    logic [51:0] m;
    int          k;
    sgn = 1'($urandom_range(0, 1));
    m = 52'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: begin
        e = 11'(1008 + $urandom_range(0, 30));
        m = {m[51:42], 42'd0};
      end
      2: begin
        e = 11'(897 + $urandom_range(0, 253));
        m = {m[51:29], 29'd0};
      end
      3: begin
        e = 11'(874 + $urandom_range(0, 22));
        k = $urandom_range(20, 52);
        m = m & ~((52'd1 << k) - 52'd1);
      end
      4: begin
        e = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
        if ($urandom_range(0, 1)) m = 52'd0;
      end
      default: begin
        e = 11'(998 + $urandom_range(0, 11));
        m = {m[51:42], 42'd0};
      end
    endcase
    return {sgn, e, m};
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 60);
    it.command = ($urandom_range(0, 9) == 0);
    it.node_type = (pick == 60) ? NT_INVALID : node_type_t'(pick % 15);
    it.indefinite = 1'($urandom_range(0, 1));
    it.last_item = ($urandom_range(0, 7) == 0);
    case (it.node_type)
      NT_DOUBLE: it.item_value = rand_double();
      NT_INT: it.item_value = $urandom_range(0, 1) ? ~rand_arg() : rand_arg();
      NT_BYTES, NT_TEXT:
        it.item_value = ($urandom_range(0, 19) == 0) ? rand_arg()
                                                      : 64'($urandom_range(0, 400));
      default: it.item_value = rand_arg();
    endcase
    return it;
  endfunction

  task automatic send_item(input item_t it, input bit known, input total_t typed);
    total_t res;
    in_valid <= 1'b1;
    command <= it.command;
    node_type <= it.node_type;
    indefinite <= it.indefinite;
    item_value <= it.item_value;
    last_item <= it.last_item;
    @(negedge clk);
    while (in_stall !== 1'b0) @(negedge clk);
    @(posedge clk);
    if (tally_item(it, res)) sizes_due.push_back(known ? typed : res);
  endtask

  task automatic pause_sender(int idx);
    if (idle_on && (idx / 50) % 4 != 3 && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // hold the input until every predicted size is out, plus the pipeline depth
  task automatic settle_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sizes_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (sizes_due.size() != 0) begin
      $display("%0t: %0d expected sizes never arrived", $time, sizes_due.size());
      mismatches += sizes_due.size();
      sizes_due.delete();
    end
  endtask

  task automatic set_float_enable(logic v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    float_en = v;
  endtask

  // receiver stalls in bursts, with calm stretches
  always @(posedge clk) begin
    cyc++;
    if (rst || !idle_on || (cyc / 200) % 4 == 1) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // outputs are settled at the falling edge; the transfer lands on the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (sizes_due.size() == 0) begin
        $display("%0t: unexpected result: encoded_size %h size_error %b", $time,
                 encoded_size, size_error);
        mismatches++;
      end else begin
        want_total = sizes_due.pop_front();
        if (encoded_size !== want_total.size) begin
          $display("%0t: encoded_size expected %h actual %h", $time, want_total.size,
                   encoded_size);
          mismatches++;
        end
        if (size_error !== want_total.err) begin
          $display("%0t: size_error expected %b actual %b", $time, want_total.err,
                   size_error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[cbor_encoded_size_accumulator] ERROR");
    $finish;
  end

  initial begin
    item_t  it;
    total_t none;

    add_row(1'b0, NT_FALSE, 1'b0, 64'd0, 1'b1, 1'b1, 64'd2, 1'b0);
    add_row(1'b0, NT_UINT, 1'b0, '1, 1'b1, 1'b1, 64'd10, 1'b0);
    // non-negative int is still inverted: all ones needs the 9-byte header
    add_row(1'b0, NT_INT, 1'b0, 64'd0, 1'b1, 1'b1, 64'd10, 1'b0);
    add_row(1'b0, NT_INVALID, 1'b0, 64'd5, 1'b1, 1'b1, 64'd0, 1'b1);
    add_row(1'b0, NT_BYTES, 1'b0, '1, 1'b1, 1'b1, 64'd0, 1'b1);
    // total lands on all ones, so the plus one overflows
    add_row(1'b0, NT_BYTES, 1'b0, 64'hFFFF_FFFF_FFFF_FFF6, 1'b1, 1'b1, 64'd0, 1'b1);
    add_row(1'b0, NT_TEXT, 1'b0, 64'hFFFF_FFFF_FFFF_FFF5, 1'b1, 1'b1, '1, 1'b0);
    add_row(1'b0, NT_ARRAY, 1'b1, 64'd1000, 1'b0);
    // break ignores the node type and is counted before the emit
    add_row(CMD_BREAK, NT_INVALID, 1'b0, 64'd0, 1'b1, 1'b1, 64'd3, 1'b0);
    add_row(1'b0, NT_TRUE, 1'b1, 64'd77, 1'b0);
    add_row(1'b0, NT_NULL, 1'b0, 64'd0, 1'b0);
    add_row(1'b0, NT_UNDEF, 1'b0, 64'd0, 1'b0);
    add_row(1'b0, NT_BYTES_CHUNKS, 1'b0, 64'd0, 1'b0);
    add_row(1'b0, NT_TEXT_CHUNKS, 1'b0, 64'd0, 1'b0);
    add_row(1'b0, NT_MAP, 1'b0, 64'h1FF, 1'b0);
    add_row(1'b0, NT_MAP, 1'b1, 64'h1FF, 1'b0);
    add_row(1'b0, NT_TAG, 1'b0, 64'd65535, 1'b0);
    add_row(1'b0, NT_SIMPLE, 1'b0, 64'd24, 1'b0);
    add_row(1'b0, NT_DOUBLE, 1'b0, 64'h8000_0000_0000_0000, 1'b0);
    add_row(1'b0, NT_DOUBLE, 1'b0, 64'h7FF8_0000_0000_0001, 1'b0);
    add_row(1'b0, NT_DOUBLE, 1'b0, 64'h3FB9_9999_A000_0000, 1'b0);
    add_row(1'b0, NT_DOUBLE, 1'b0, 64'h3E70_0000_0000_0000, 1'b0);
    add_row(1'b0, NT_DOUBLE, 1'b0, 64'h36A0_0000_0000_0000, 1'b0);
    add_row(1'b0, NT_DOUBLE, 1'b0, 64'h0000_0000_0000_0001, 1'b1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < dir_rows.size(); i++) begin
      none.size = dir_rows[i].size;
      none.err = dir_rows[i].err;
      send_item(dir_rows[i].it, dir_rows[i].known, none);
      pause_sender(i);
    end

    // float_enable alternates per phase; the last phase runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      settle_results();
      set_float_enable(1'(ph % 2));
      if (ph == 3) idle_on = 1'b0;
      for (int n = 0; n < 288; n++) begin
        it = rand_item();
        if (n == 287) it.last_item = 1'b1;
        send_item(it, 1'b0, none);
        pause_sender(n);
      end
    end

    settle_results();
    if (mismatches == 0) begin
      $display("[cbor_encoded_size_accumulator] OK");
    end else begin
      $display("[cbor_encoded_size_accumulator] ERROR");
    end
    $finish;
  end

endmodule
